// ----- rtl/idiv_pkg.sv -----
package idiv_pkg;

  // operand width used by the divider core
  localparam int DATA_WIDTH = 64;
  // fixed width of the dividend, divisor and result fields on the channels
  localparam int FIELD_W    = 64;
  localparam int REQ_W      = 2;
  // iteration counter width, indexes one quotient bit per step
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef enum logic [REQ_W-1:0] {
    REQ_UQUO = 2'd0,
    REQ_UREM = 2'd1,
    REQ_SQUO = 2'd2,
    REQ_SREM = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } idiv_cmd_t;

endpackage

// ----- rtl/idiv_in_if.sv -----
interface idiv_in_if;
  logic                          valid;
  logic                          ready;
  logic [idiv_pkg::FIELD_W-1:0]  dividend;
  logic [idiv_pkg::FIELD_W-1:0]  divisor;
  logic [idiv_pkg::REQ_W-1:0]    req_type;

  modport source (output valid, output dividend, output divisor, output req_type,
                  input ready);
  modport sink   (input valid, input dividend, input divisor, input req_type,
                  output ready);
endinterface

// ----- rtl/idiv_out_if.sv -----
interface idiv_out_if;
  logic                          valid;
  logic                          ready;
  logic [idiv_pkg::FIELD_W-1:0]  result;
  logic                          div_by_zero;

  modport source (output valid, output result, output div_by_zero, input ready);
  modport sink   (input valid, input result, input div_by_zero, output ready);
endinterface

// ----- rtl/idiv_ctrl.sv -----
module idiv_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output idiv_pkg::idiv_cmd_t  cmd
);

  idiv_pkg::state_t             state_r, state_nxt;
  logic [idiv_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      idiv_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = idiv_pkg::ST_CALC;
      end
      idiv_pkg::ST_CALC: begin
        if (cnt_r == idiv_pkg::CNT_W'(0)) state_nxt = idiv_pkg::ST_FINISH;
      end
      idiv_pkg::ST_FINISH: begin
        if (slot_free) state_nxt = idiv_pkg::ST_IDLE;
      end
      default: state_nxt = idiv_pkg::ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      idiv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      idiv_pkg::ST_CALC: begin
        cmd.step = 1'b1;
      end
      idiv_pkg::ST_FINISH: begin
        cmd.finish = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // iteration counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = idiv_pkg::CNT_W'(idiv_pkg::DATA_WIDTH - 1);
    end else if (cmd.step && cnt_r != idiv_pkg::CNT_W'(0)) begin
      cnt_nxt = cnt_r - idiv_pkg::CNT_W'(1);
    end
  end

  // output valid flag of the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= idiv_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a result is only written into a free or draining output register
  a_finish_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result written over an untaken transaction");

  // the last iteration always leads to the finish state
  a_calc_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == idiv_pkg::ST_CALC && cnt_r == idiv_pkg::CNT_W'(0))
      |=> state_r == idiv_pkg::ST_FINISH)
    else $error("iteration count did not end in finish");

  // a load starts a full run of iterations
  a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == idiv_pkg::ST_CALC &&
                  cnt_r == idiv_pkg::CNT_W'(idiv_pkg::DATA_WIDTH - 1)))
    else $error("load did not start the iteration");

endmodule

// ----- rtl/idiv_dp.sv -----
module idiv_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  idiv_pkg::idiv_cmd_t           cmd,
  input  logic [idiv_pkg::FIELD_W-1:0]  dividend,
  input  logic [idiv_pkg::FIELD_W-1:0]  divisor,
  input  logic [idiv_pkg::REQ_W-1:0]    req_type,
  output logic [idiv_pkg::FIELD_W-1:0]  result,
  output logic                          div_by_zero
);

  localparam int DW = idiv_pkg::DATA_WIDTH;

  logic [DW-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]  quo_r, quo_nxt;
  logic [DW-1:0]  div_r;
  logic [DW-1:0]  num_r;
  logic           neg_q_r, neg_r_r, rem_mode_r, dbz_r;
  logic [DW-1:0]  res_r;
  logic           res_dbz_r;

  logic [DW-1:0]  n_in, d_in, un, ud;
  logic           is_signed, want_rem, nneg, dneg;
  logic [DW:0]    shifted;
  logic [DW+1:0]  trial;
  logic [DW-1:0]  sel_val, res_nxt;
  logic           sel_neg;

  // operand decode and magnitudes
  always_comb begin
    n_in      = dividend[DW-1:0];
    d_in      = divisor[DW-1:0];
    want_rem  = (req_type == idiv_pkg::REQ_UREM) || (req_type == idiv_pkg::REQ_SREM);
    is_signed = (req_type == idiv_pkg::REQ_SQUO) || (req_type == idiv_pkg::REQ_SREM);
    nneg      = is_signed && n_in[DW-1];
    dneg      = is_signed && d_in[DW-1];
    un        = nneg ? (DW'(0) - n_in) : n_in;
    ud        = dneg ? (DW'(0) - d_in) : d_in;
  end

  // one restoring step: shift in the next dividend bit, trial subtract
  always_comb begin
    shifted = {rem_r, quo_r[DW-1]};
    trial   = {1'b0, shifted} - {2'b00, div_r};
    if (!trial[DW+1]) begin
      rem_nxt = trial[DW-1:0];
      quo_nxt = {quo_r[DW-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DW-1:0];
      quo_nxt = {quo_r[DW-2:0], 1'b0};
    end
  end

  // final sign fix and divide by zero fallback
  always_comb begin
    sel_val = rem_mode_r ? rem_r : quo_r;
    sel_neg = rem_mode_r ? neg_r_r : neg_q_r;
    if (dbz_r) begin
      res_nxt = rem_mode_r ? num_r : '1;
    end else begin
      res_nxt = sel_neg ? (DW'(0) - sel_val) : sel_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r      <= '0;
      quo_r      <= un;
      div_r      <= ud;
      num_r      <= n_in;
      neg_q_r    <= nneg ^ dneg;
      neg_r_r    <= nneg;
      rem_mode_r <= want_rem;
      dbz_r      <= (d_in == '0);
    end else if (cmd.step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.finish) begin
      res_r     <= res_nxt;
      res_dbz_r <= dbz_r;
    end
  end

  assign result      = idiv_pkg::FIELD_W'(res_r);
  assign div_by_zero = res_dbz_r;

  // partial remainder stays below the divisor while iterating
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && !dbz_r) |=> rem_r < div_r)
    else $error("partial remainder not below divisor");

  // quotient requests on a zero divisor give all ones
  a_dbz_quo: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && dbz_r && !rem_mode_r) |=> res_r == '1)
    else $error("divide by zero quotient not all ones");

  // remainder requests on a zero divisor give back the dividend
  a_dbz_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && dbz_r && rem_mode_r) |=> res_r == $past(num_r))
    else $error("divide by zero remainder not the dividend");

endmodule

// ----- rtl/integer_divider_64_top.sv -----
// Radix-2 restoring integer divider: one transaction on in_ch carries a dividend,
// a divisor and a request (unsigned or signed, quotient or remainder), and yields
// exactly one transaction on out_ch. After acceptance the core works out one quotient
// bit per step through the single shared subtractor, then fixes the sign in a final
// state that writes the result register. The request side opens in the same cycle
// as the result becomes valid, so a new transaction is taken only once the previous
// result is written. The result sits in an output register, so the next transaction
// can be accepted while the previous result waits to be taken; if that register is
// still full when the following result is done, the core holds it and the
// transaction stretches by the stall. A zero divisor raises div_by_zero and returns
// all ones for a quotient or the dividend for a remainder; the most negative value
// divided by minus one wraps to itself with a zero remainder.
module integer_divider_64_top (
  input  logic             clk,
  input  logic             rst_n,
  idiv_in_if.sink          in_ch,
  idiv_out_if.source       out_ch
);

  idiv_pkg::idiv_cmd_t cmd;

  idiv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  idiv_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .dividend    (in_ch.dividend),
    .divisor     (in_ch.divisor),
    .req_type    (in_ch.req_type),
    .result      (out_ch.result),
    .div_by_zero (out_ch.div_by_zero)
  );

endmodule
